@@ sv/u8tok_pkg.sv @@
`default_nettype none

package u8tok_pkg;

  // Fixed field widths of the stream items.
  localparam int BYTE_W  = 8;
  localparam int TOKEN_W = 12;
  localparam int CP_W    = 21;
  localparam int POS_W   = 8;

  // Tokenizer limits.
  localparam int MAX_TOKENS = 256;
  localparam int VOCAB_SIZE = 4096;

  // The counter must be able to hold MAX_TOKENS itself.
  localparam int CNT_W = $clog2(MAX_TOKENS + 1);

  localparam logic [CP_W-1:0]  VOCAB_MASK = CP_W'(VOCAB_SIZE - 1);
  localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_TOKENS);

  // Packed widths on the result channel.
  localparam int OUT_FIELDS_W = TOKEN_W + CP_W + POS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Lead byte classes.
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  typedef struct packed {
    logic [1:0]       pending;
    logic [CP_W-1:0]  partial;
    logic [CNT_W-1:0] count;
    logic             ended;
  } dec_state_t;

  typedef struct packed {
    logic               emit;
    logic [TOKEN_W-1:0] token;
    logic [CP_W-1:0]    code_point;
    logic [POS_W-1:0]   position;
    logic               bad_lead;
  } dec_result_t;

endpackage

`default_nettype wire

@@ sv/u8tok_decode.sv @@
`default_nettype none

module u8tok_decode
  import u8tok_pkg::*;
(
  input  wire logic [BYTE_W-1:0] byte_i,
  input  wire logic              start_i,
  input  wire dec_state_t        state_i,
  output dec_state_t             state_o,
  output dec_result_t            result_o
);

  dec_state_t      st;
  logic            fire;
  logic [CP_W-1:0] cp;
  logic            bad;
  logic            room;

  // Decode step: assembles UTF-8 sequences into codepoints, masks the codepoint into a token and stamps the position.
  always_comb begin
    st   = start_i ? '0 : state_i;
    fire = 1'b0;
    cp   = '0;
    bad  = 1'b0;
    room = (st.count < CNT_MAX);
    state_o = st;

    if (st.ended) begin
      state_o = st;
    end else if (st.pending != 2'd0) begin
      state_o.partial = {st.partial[CP_W-7:0], byte_i[5:0]};
      state_o.pending = st.pending - 2'd1;
      if (st.pending == 2'd1) begin
        fire = room;
        cp   = {st.partial[CP_W-7:0], byte_i[5:0]};
      end
    end else if (byte_i == '0) begin
      state_o.ended = 1'b1;
    end else if (room) begin
      if (!byte_i[7]) begin
        fire = 1'b1;
        cp   = CP_W'(byte_i);
      end else if (byte_i[7:5] == LEAD2_TAG) begin
        state_o.partial = CP_W'(byte_i[4:0]);
        state_o.pending = 2'd1;
      end else if (byte_i[7:4] == LEAD3_TAG) begin
        state_o.partial = CP_W'(byte_i[3:0]);
        state_o.pending = 2'd2;
      end else if (byte_i[7:3] == LEAD4_TAG) begin
        state_o.partial = CP_W'(byte_i[2:0]);
        state_o.pending = 2'd3;
      end else begin
        fire = 1'b1;
        cp   = CP_W'(byte_i);
        bad  = 1'b1;
      end
    end

    if (fire) begin
      state_o.count = st.count + CNT_W'(1);
    end

    result_o.emit       = fire;
    result_o.code_point = cp;
    result_o.token      = TOKEN_W'(cp & VOCAB_MASK);
    result_o.position   = POS_W'(st.count);
    result_o.bad_lead   = bad;
  end

endmodule

`default_nettype wire

@@ sv/utf8_codepoint_tokenizer.sv @@
`default_nettype none
// An accepted byte is held in the input register and decoded; its token loads the result register.
// Throughput: one byte per cycle; the input register, decode and result register form a
// two-stage pipeline that stalls only when the result register holds an untaken token.
// Reset (rst_n low, synchronous): clears the decoder state, the token count and both valid
// flags, so the first bytes after reset belong to a fresh text.

module utf8_codepoint_tokenizer
  import u8tok_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input stream, one text byte per transaction.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [BYTE_W-1:0]      in_tdata,   // [7:0] text_byte
  input  wire logic [0:0]             in_tuser,   // [0] text_start
  // Result stream, one token per transaction.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [11:0] token, [32:12] code_point,
                                                  // [40:33] position, [47:41] zero
  output logic [0:0]                  out_tuser   // [0] bad_lead
);

  // Stage 1 holds the raw byte. Its valid flag is control and is reset; the byte is not.
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_start_r;

  // Decoder state that runs across bytes of a text.
  dec_state_t  st_r;
  dec_state_t  st_nxt;
  dec_result_t res;

  // Result register in front of the output port.
  logic        out_valid_r;
  logic        out_valid_nxt;
  dec_result_t out_res_r;

  logic out_free;
  logic s1_advance;
  logic in_take;

  u8tok_decode u_decode (
    .byte_i   (s1_byte_r),
    .start_i  (s1_start_r),
    .state_i  (st_r),
    .state_o  (st_nxt),
    .result_o (res)
  );

  // The result register can load when it is empty or its token leaves this cycle.
  // A byte that produces no token never waits for the output side.
  assign out_free   = !out_valid_r || out_tready;
  assign s1_advance = s1_valid_r && (out_free || !res.emit);
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_take    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_r);
    if (s1_advance && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser[0];
    end
    if (s1_advance && res.emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.position, out_res_r.code_point, out_res_r.token});
  assign out_tuser  = out_res_r.bad_lead;

  // The token count never passes the limit.
  a_count_limit : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.count <= CNT_MAX)
    else $error("token count above limit");

  // An ended text has no sequence in progress.
  a_ended_idle : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.ended |-> st_r.pending == 2'd0)
    else $error("pending bytes after end of text");

  // The token is always the masked codepoint of the same result.
  a_token_mask : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.token == TOKEN_W'(out_res_r.code_point & VOCAB_MASK))
    else $error("token does not match codepoint");

  // A flagged lead byte passes through as a codepoint of 0x80 to 0xFF.
  a_bad_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.bad_lead) |->
      (out_res_r.code_point[CP_W-1:BYTE_W] == '0 && out_res_r.code_point[BYTE_W-1]))
    else $error("flagged codepoint out of range");

  // A token waiting on a stalled output holds until taken.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("result register changed while stalled");

endmodule

`default_nettype wire
